/* design/segment_intersection_2d_unit_assert.svh */
// Assertion macros for the segment intersection unit.
`ifndef SEGMENT_INTERSECTION_2D_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_2D_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles.
`define SIS_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* design/sis_pkg.sv */
`timescale 1ns / 1ps
package sis_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int FRAC_W  = 16;
  localparam int Q_W     = 32;
  localparam int DEN_W   = NUM_W + FRAC_W;
  localparam int REM_W   = DEN_W + 1;
  localparam int DMIN_W  = 40;
  localparam int TOL_W   = 16;
  localparam int CFG_W   = 40;
  localparam int CMP_W   = Q_W + 2;

  // divider: one input stage plus one stage per quotient bit
  localparam int DIV_LAT  = Q_W + 1;
  // front (3) + magnitude stage + divider + saturate + hit/output
  localparam int PIPE_LAT = 4 + DIV_LAT + 2;

  localparam logic CFG_DET_MIN   = 1'b0;
  localparam logic CFG_PARAM_TOL = 1'b1;

  localparam logic [DMIN_W-1:0] DET_MIN_RST = 40'd1;
  localparam logic [TOL_W-1:0]  TOL_RST     = 16'd1;

  localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;
  localparam logic [Q_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] a0_x;
    logic signed [COORD_W-1:0] a0_z;
    logic signed [COORD_W-1:0] a1_x;
    logic signed [COORD_W-1:0] a1_z;
    logic signed [COORD_W-1:0] b0_x;
    logic signed [COORD_W-1:0] b0_z;
    logic signed [COORD_W-1:0] b1_x;
    logic signed [COORD_W-1:0] b1_z;
  } seg_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] param_s;
    logic signed [Q_W-1:0] param_t;
    logic                  parallel;
    logic                  hit;
  } seg_out_t;

  // determinant and the two numerators
  typedef struct packed {
    logic signed [NUM_W-1:0] det;
    logic signed [NUM_W-1:0] num_s;
    logic signed [NUM_W-1:0] num_t;
  } cross_t;

  // side info that rides alongside the dividers
  typedef struct packed {
    logic vld;
    logic par;
    logic neg_s;
    logic neg_t;
  } side_t;

endpackage

/* design/sis_front.sv */
`timescale 1ns / 1ps
module sis_front import sis_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  seg_in_t item_i,
  output logic    vld_o,
  output cross_t  cross_o
);

  logic signed [DIFF_W-1:0] ux_q, uz_q, vx_q, vz_q, wx_q, wz_q;
  logic signed [PROD_W-1:0] vxuz_q, vzux_q, vzwx_q, vxwz_q, uzwx_q, uxwz_q;
  cross_t cross_q;
  logic [2:0] vld_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // stage 1: difference vectors
  always_ff @(posedge clk_i) begin
    ux_q <= DIFF_W'(item_i.a1_x) - DIFF_W'(item_i.a0_x);
    uz_q <= DIFF_W'(item_i.a1_z) - DIFF_W'(item_i.a0_z);
    vx_q <= DIFF_W'(item_i.b1_x) - DIFF_W'(item_i.b0_x);
    vz_q <= DIFF_W'(item_i.b1_z) - DIFF_W'(item_i.b0_z);
    wx_q <= DIFF_W'(item_i.a0_x) - DIFF_W'(item_i.b0_x);
    wz_q <= DIFF_W'(item_i.a0_z) - DIFF_W'(item_i.b0_z);
  end

  // stage 2: cross products
  always_ff @(posedge clk_i) begin
    vxuz_q <= vx_q * uz_q;
    vzux_q <= vz_q * ux_q;
    vzwx_q <= vz_q * wx_q;
    vxwz_q <= vx_q * wz_q;
    uzwx_q <= uz_q * wx_q;
    uxwz_q <= ux_q * wz_q;
  end

  // stage 3: determinant and numerators
  always_ff @(posedge clk_i) begin
    cross_q.det   <= NUM_W'(vxuz_q) - NUM_W'(vzux_q);
    cross_q.num_s <= NUM_W'(vzwx_q) - NUM_W'(vxwz_q);
    cross_q.num_t <= NUM_W'(uzwx_q) - NUM_W'(uxwz_q);
  end

  assign vld_o   = vld_q[2];
  assign cross_o = cross_q;

endmodule

/* design/sis_div.sv */
`timescale 1ns / 1ps
module sis_div import sis_pkg::*; (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [NUM_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o,
  output logic             ovf_o
);

  // restoring fractional division: rem < den, one quotient bit per stage
  logic [REM_W-1:0] rem_q [0:Q_W];
  logic [DEN_W-1:0] den_q [0:Q_W];
  logic [Q_W-1:0]   quo_q [0:Q_W];
  logic             ovf_q [0:Q_W];

  // input stage: scale divisor, flag integer part >= 2^16
  always_ff @(posedge clk_i) begin
    rem_q[0] <= REM_W'(num_i);
    den_q[0] <= {den_i, FRAC_W'(0)};
    quo_q[0] <= '0;
    ovf_q[0] <= DEN_W'(num_i) >= {den_i, FRAC_W'(0)};
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [REM_W-1:0] shl, dif;
    logic             ge;
    assign shl = {rem_q[k-1][REM_W-2:0], 1'b0};
    assign dif = shl - REM_W'(den_q[k-1]);
    assign ge  = shl >= REM_W'(den_q[k-1]);

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? dif : shl;
      quo_q[k] <= {quo_q[k-1][Q_W-2:0], ge};
      den_q[k] <= den_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
    end
  end

  assign quo_o = quo_q[Q_W];
  assign ovf_o = ovf_q[Q_W];

endmodule

/* design/segment_intersection_2d_unit.sv */
`timescale 1ns / 1ps
// The result strobe follows the start beat through the front, magnitude, divider, saturation and output stages.
// Throughput: one segment pair per cycle; busy_o stays low and the receiver cannot stall.
// Depth is set by the two 33-stage restoring dividers, one quotient bit per stage.
// Reset clears all valid bits and sets det_min and param_tol to 1.
module segment_intersection_2d_unit import sis_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  seg_in_t          item_i,
  output logic             result_valid_o,
  output seg_out_t         result_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  `include "segment_intersection_2d_unit_assert.svh"

  logic [DMIN_W-1:0] det_min_q;
  logic [TOL_W-1:0]  tol_q;

  logic   fr_vld;
  cross_t fr_cross;

  logic [NUM_W-1:0] mag_det_q, mag_s_q, mag_t_q;
  side_t            side_q;
  side_t            dly_q [0:DIV_LAT-1];

  logic [Q_W-1:0] quo_s, quo_t;
  logic           ovf_s, ovf_t;

  logic           f1_vld_q, f1_par_q;
  logic [Q_W-1:0] f1_s_q, f1_t_q;

  logic     out_vld_q;
  seg_out_t out_q;

  function automatic logic [NUM_W-1:0] mag_of(logic signed [NUM_W-1:0] x);
    return x[NUM_W-1] ? NUM_W'(-x) : NUM_W'(x);
  endfunction

  function automatic logic [Q_W-1:0] sat_q16(logic [Q_W-1:0] q, logic ovf, logic neg);
    logic [Q_W-1:0] r;
    if (ovf) begin
      r = neg ? SAT_NEG : SAT_POS;
    end else if (neg) begin
      r = (q > SAT_NEG) ? SAT_NEG : (~q + Q_W'(1));
    end else begin
      r = (q > SAT_POS) ? SAT_POS : q;
    end
    return r;
  endfunction

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_min_q <= DET_MIN_RST;
      tol_q     <= TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DET_MIN:   det_min_q <= cfg_data_i[DMIN_W-1:0];
        CFG_PARAM_TOL: tol_q     <= cfg_data_i[TOL_W-1:0];
        default:       ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  sis_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start_i),
    .item_i  (item_i),
    .vld_o   (fr_vld),
    .cross_o (fr_cross)
  );

  // stage 4: magnitudes
  always_ff @(posedge clk_i) begin
    mag_det_q <= mag_of(fr_cross.det);
    mag_s_q   <= mag_of(fr_cross.num_s);
    mag_t_q   <= mag_of(fr_cross.num_t);
  end

  // stage 4: valid, quotient signs, parallel test
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q.vld   <= fr_vld;
      side_q.par   <= (fr_cross.det == '0) ||
                      (mag_of(fr_cross.det) < NUM_W'(det_min_q));
      side_q.neg_s <= fr_cross.num_s[NUM_W-1] ^ fr_cross.det[NUM_W-1];
      side_q.neg_t <= fr_cross.num_t[NUM_W-1] ^ fr_cross.det[NUM_W-1];
    end
  end

  sis_div u_div_s (
    .clk_i (clk_i),
    .num_i (mag_s_q),
    .den_i (mag_det_q),
    .quo_o (quo_s),
    .ovf_o (ovf_s)
  );

  sis_div u_div_t (
    .clk_i (clk_i),
    .num_i (mag_t_q),
    .den_i (mag_det_q),
    .quo_o (quo_t),
    .ovf_o (ovf_t)
  );

  // side info delay line matching the dividers
  for (genvar k = 0; k < DIV_LAT; k++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dly_q[k] <= '0;
      end else begin
        dly_q[k] <= (k == 0) ? side_q : dly_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // stage: sign and saturation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else begin
      f1_vld_q <= dly_q[DIV_LAT-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_par_q <= dly_q[DIV_LAT-1].par;
    f1_s_q   <= dly_q[DIV_LAT-1].par ? '0 : sat_q16(quo_s, ovf_s, dly_q[DIV_LAT-1].neg_s);
    f1_t_q   <= dly_q[DIV_LAT-1].par ? '0 : sat_q16(quo_t, ovf_t, dly_q[DIV_LAT-1].neg_t);
  end

  // hit window (-tol, 1 + tol)
  logic signed [CMP_W-1:0] s_x, t_x, lo_x, hi_x;
  logic                    hit_d;
  always_comb begin
    s_x   = CMP_W'($signed(f1_s_q));
    t_x   = CMP_W'($signed(f1_t_q));
    lo_x  = -$signed(CMP_W'(tol_q));
    hi_x  = $signed(CMP_W'(ONE_Q16)) + $signed(CMP_W'(tol_q));
    hit_d = !f1_par_q && (s_x > lo_x) && (s_x < hi_x) && (t_x > lo_x) && (t_x < hi_x);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.param_s  <= f1_s_q;
    out_q.param_t  <= f1_t_q;
    out_q.parallel <= f1_par_q;
    out_q.hit      <= hit_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

  // parallel result beat and its zeroed parameters
  logic par_beat, params_zero;
  assign par_beat    = result_valid_o && result_o.parallel;
  assign params_zero = (result_o.param_s == '0) && (result_o.param_t == '0);

  `SIS_ASSERT_NOW(a_par_no_hit, par_beat, !result_o.hit, "hit on parallel beat")
  `SIS_ASSERT_NOW(a_par_zero, par_beat, params_zero, "nonzero params on parallel beat")
  `SIS_ASSERT_DLY(a_lat, start_i && !busy_o, PIPE_LAT, result_valid_o, "result beat missing")

endmodule
